/* sv/tcg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcg_pkg: shared types and constants of the text cell grid engine
// Operation and status codes, field widths, cell layout and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcg_pkg;

   // field widths
   localparam int OP_W   = 2;
   localparam int ROW_W  = 8;
   localparam int COL_W  = 9;
   localparam int CHAR_W = 21;
   localparam int HL_W   = 16;
   localparam int REP_W  = 16;
   localparam int SROW_W = 9;
   localparam int SCOL_W = 9;
   localparam int ST_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   // operation codes
   localparam logic [OP_W-1:0] OP_RUN    = 2'd0;
   localparam logic [OP_W-1:0] OP_SCROLL = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_READ   = 2'd3;

   // result status codes
   localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
   localparam logic [ST_W-1:0] ST_REJECT = 2'd1;
   localparam logic [ST_W-1:0] ST_UNSUP  = 2'd2;
   localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

   // reset values of the configuration registers
   localparam logic [COL_W-1:0] GRID_WIDTH_RST  = 9'd80;
   localparam logic [ROW_W-1:0] GRID_HEIGHT_RST = 8'd24;

   // one stored cell
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic [HL_W-1:0]   hl;
   } cell_type;

   // controller to datapath
   typedef struct packed {
      logic accept;    // latch the incoming item
      logic decode;    // record status, set up cursor and scroll counters
      logic run_step;  // write one cell of a run
      logic sc_read;   // read scroll source cell
      logic sc_copy;   // write read cell to scroll target, advance
      logic sc_blank;  // blank scroll source cell, advance
      logic clr_step;  // blank one store entry
      logic rd_issue;  // read the addressed cell
      logic load_rsp;  // move the result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic go;         // item needs work beyond decode
      logic run_last;   // current run cell is the last one
      logic sc_tgt_ok;  // scroll target row lies on the grid
      logic sc_last;    // current scroll cell is the last one
      logic clr_last;   // sweep is at the last entry
      logic rsp_free;   // output register can take a result
   } sts_type;

endpackage
`default_nettype wire

/* sv/tcg_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcg_ctrl: sequencer of the text cell grid engine
// Runs the reset sweep, takes items, and steps run writes, scrolls, clears
// and reads through the datapath one store access per cycle.
// ----------------------------------------------------------------------------
module tcg_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcg_pkg::sts_type sts,
   output tcg_pkg::cmd_type cmd
);
   import tcg_pkg::*;

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_RUN    = 3'd3;
   localparam logic [2:0] S_SC_RD  = 3'd4;
   localparam logic [2:0] S_SC_WR  = 3'd5;
   localparam logic [2:0] S_CLEAR  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            unique case (sts.op)
               OP_RUN:    state_in = sts.go ? S_RUN : S_DONE;
               OP_SCROLL: state_in = sts.go ? S_SC_RD : S_DONE;
               OP_CLEAR:  state_in = S_CLEAR;
               OP_READ: begin
                  cmd.rd_issue = sts.go;
                  state_in     = S_DONE;
               end
            endcase
         end
         S_RUN: begin
            cmd.run_step = 1'b1;
            if (sts.run_last) state_in = S_DONE;
         end
         S_SC_RD: begin
            // copy takes a read and a write, blanking a single write
            if (sts.sc_tgt_ok) begin
               cmd.sc_read = 1'b1;
               state_in    = S_SC_WR;
            end else begin
               cmd.sc_blank = 1'b1;
               if (sts.sc_last) state_in = S_DONE;
            end
         end
         S_SC_WR: begin
            cmd.sc_copy = 1'b1;
            state_in    = sts.sc_last ? S_DONE : S_SC_RD;
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule
`default_nettype wire

/* sv/tcg_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcg_datapath: cell store and item registers of the text cell grid engine
// Holds the single-port cell memory, the size registers, the write cursor,
// the run and scroll counters, the clear sweep and the output register.
// ----------------------------------------------------------------------------
module tcg_datapath #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tcg_pkg::cmd_type                      cmd,
   output tcg_pkg::sts_type                      sts,
   input  logic [tcg_pkg::OP_W-1:0]              req_op,
   input  logic [tcg_pkg::ROW_W-1:0]             req_row,
   input  logic [tcg_pkg::COL_W-1:0]             req_col,
   input  logic                                  req_line_start,
   input  logic [tcg_pkg::CHAR_W-1:0]            req_char_code,
   input  logic [tcg_pkg::HL_W-1:0]              req_highlight,
   input  logic [tcg_pkg::REP_W-1:0]             req_repeat_req,
   input  logic [tcg_pkg::ROW_W-1:0]             req_bottom,
   input  logic [tcg_pkg::COL_W-1:0]             req_right_edge,
   input  logic signed [tcg_pkg::SROW_W-1:0]     req_scroll_rows,
   input  logic signed [tcg_pkg::SCOL_W-1:0]     req_scroll_cols,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tcg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tcg_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [tcg_pkg::CHAR_W-1:0]            rsp_cell_char,
   output logic [tcg_pkg::HL_W-1:0]              rsp_cell_highlight,
   output logic [tcg_pkg::ST_W-1:0]              rsp_status
);
   import tcg_pkg::*;

   localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam logic [AW-1:0] LAST_ADDR = AW'(CELL_COUNT - 1);

   // cell address at a fixed row stride
   function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
      return AW'(r) * AW'(MAX_WIDTH) + AW'(c);
   endfunction

   // latched item
   logic [OP_W-1:0]          op_ff;
   logic [ROW_W-1:0]         row_ff;
   logic [COL_W-1:0]         col_ff;
   logic                     ls_ff;
   cell_type                 run_cell_ff;
   logic [ROW_W-1:0]         bottom_ff;
   logic [COL_W-1:0]         right_ff;
   logic [SROW_W-1:0]        rows_ff;
   logic [SCOL_W-1:0]        cols_ff;

   // control registers and their next values
   logic [COL_W-1:0]  width_ff,    width_in;
   logic [ROW_W-1:0]  height_ff,   height_in;
   logic [ROW_W-1:0]  cur_row_ff,  cur_row_in;
   logic [COL_W-1:0]  cur_col_ff,  cur_col_in;
   logic              line_ok_ff,  line_ok_in;
   logic [REP_W-1:0]  rem_ff,      rem_in;
   logic [ROW_W-1:0]  sr_ff,       sr_in;
   logic [COL_W-1:0]  sc_ff,       sc_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [ST_W-1:0]   st_ff,       st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff,  rsp_char_in;
   logic [HL_W-1:0]   rsp_hl_ff,    rsp_hl_in;
   logic [ST_W-1:0]   rsp_st_ff,    rsp_st_in;

   // cell memory
   cell_type          mem [CELL_COUNT];
   cell_type          rd_data_ff;
   logic [AW-1:0]     mem_addr;
   logic [ROW_W-1:0]  addr_row;
   logic [COL_W-1:0]  addr_col;
   logic              mem_we;
   logic              mem_re;
   cell_type          mem_wdata;

   // decode helpers
   logic [COL_W-1:0]      eff_w;
   logic [ROW_W-1:0]      eff_h;
   logic                  start_ok;
   logic                  run_ok;
   logic [ROW_W-1:0]      run_row;
   logic [COL_W-1:0]      run_col;
   logic [SROW_W-1:0]     mag;
   logic                  up;
   logic [ST_W-1:0]       dec_st;
   logic signed [ROW_W+1:0] tgt;
   logic                  tgt_ok;
   logic                  last_col;
   logic                  last_row;
   logic                  sc_step;
   logic                  clr_last;

   // size in use is limited by the store
   assign eff_w = (32'(width_ff) < MAX_WIDTH) ? width_ff : COL_W'(MAX_WIDTH);
   assign eff_h = (32'(height_ff) < MAX_HEIGHT) ? height_ff : ROW_W'(MAX_HEIGHT);

   // run write checks, with a new line taking effect at once
   assign start_ok = (row_ff < eff_h) && (col_ff < eff_w);
   assign run_ok   = ls_ff ? start_ok : line_ok_ff;
   assign run_row  = ls_ff ? row_ff : cur_row_ff;
   assign run_col  = ls_ff ? col_ff : cur_col_ff;

   // scroll direction and magnitude
   assign up  = ~rows_ff[SROW_W-1];
   assign mag = rows_ff[SROW_W-1] ? (~rows_ff + SROW_W'(1)) : rows_ff;

   // status of the item at decode
   always_comb begin
      dec_st = ST_DONE;
      unique case (op_ff)
         OP_RUN: begin
            if (!run_ok || (run_row >= eff_h)) begin
               dec_st = ST_REJECT;
            end else if ((rem_ff == '0) || (run_col >= eff_w)) begin
               dec_st = ST_EMPTY;
            end
         end
         OP_SCROLL: begin
            if (cols_ff != '0) begin
               dec_st = ST_UNSUP;
            end else if ((eff_w == '0) || (eff_h == '0)) begin
               dec_st = ST_REJECT;
            end else if ((row_ff >= bottom_ff) || (bottom_ff > eff_h)) begin
               dec_st = ST_REJECT;
            end else if ((col_ff >= right_ff) || (right_ff > eff_w)) begin
               dec_st = ST_REJECT;
            end else if (mag > {1'b0, eff_h}) begin
               dec_st = ST_REJECT;
            end else if (rows_ff == '0) begin
               dec_st = ST_EMPTY;
            end
         end
         OP_CLEAR: dec_st = ST_DONE;
         OP_READ: begin
            if (!start_ok) dec_st = ST_REJECT;
         end
      endcase
   end

   // scroll walk: target row and end of row / region
   assign tgt      = $signed({2'b00, sr_ff}) - $signed({rows_ff[SROW_W-1], rows_ff});
   assign tgt_ok   = !tgt[ROW_W+1] && (tgt[ROW_W:0] < {1'b0, eff_h});
   assign last_col = (sc_ff == (right_ff - COL_W'(1)));
   assign last_row = up ? (sr_ff == (bottom_ff - ROW_W'(1))) : (sr_ff == row_ff);
   assign sc_step  = cmd.sc_copy | cmd.sc_blank;
   assign clr_last = (clr_addr_ff == LAST_ADDR);

   // status to the controller
   always_comb begin
      sts           = '0;
      sts.op        = op_ff;
      sts.go        = (dec_st == ST_DONE);
      sts.run_last  = (rem_ff == REP_W'(1)) ||
                      (({1'b0, cur_col_ff} + (COL_W+1)'(1)) >= {1'b0, eff_w});
      sts.sc_tgt_ok = tgt_ok;
      sts.sc_last   = last_col && last_row;
      sts.clr_last  = clr_last;
      sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // next values of control registers
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      line_ok_in   = line_ok_ff;
      rem_in       = rem_ff;
      sr_in        = sr_ff;
      sc_in        = sc_ff;
      clr_addr_in  = clr_addr_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_hl_in    = rsp_hl_ff;
      rsp_st_in    = rsp_st_ff;

      // configuration writes
      if (csr_valid) begin
         unique case (csr_index)
            REG_GRID_WIDTH:  width_in  = csr_wdata;
            REG_GRID_HEIGHT: height_in = csr_wdata[ROW_W-1:0];
         endcase
      end

      if (cmd.accept) rem_in = req_repeat_req;

      // decode: status, new line, scroll start point
      if (cmd.decode) begin
         st_in = dec_st;
         if ((op_ff == OP_RUN) && ls_ff) begin
            line_ok_in = start_ok;
            if (start_ok) begin
               cur_row_in = row_ff;
               cur_col_in = col_ff;
            end
         end
         sr_in = up ? row_ff : (bottom_ff - ROW_W'(1));
         sc_in = col_ff;
      end

      // run write steps along the row
      if (cmd.run_step) begin
         cur_col_in = cur_col_ff + COL_W'(1);
         rem_in     = rem_ff - REP_W'(1);
      end

      // scroll steps across columns, then rows
      if (sc_step) begin
         if (last_col) begin
            sc_in = col_ff;
            sr_in = up ? (sr_ff + ROW_W'(1)) : (sr_ff - ROW_W'(1));
         end else begin
            sc_in = sc_ff + COL_W'(1);
         end
      end

      // clear sweep
      if (cmd.clr_step) clr_addr_in = clr_last ? '0 : (clr_addr_ff + AW'(1));

      // output register
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_st_in    = st_ff;
         if ((op_ff == OP_READ) && (st_ff == ST_DONE)) begin
            rsp_char_in = rd_data_ff.ch;
            rsp_hl_in   = rd_data_ff.hl;
         end else begin
            rsp_char_in = '0;
            rsp_hl_in   = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= GRID_WIDTH_RST;
         height_ff    <= GRID_HEIGHT_RST;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         line_ok_ff   <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         line_ok_ff   <= line_ok_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      sr_ff       <= sr_in;
      sc_ff       <= sc_in;
      st_ff       <= st_in;
      rsp_char_ff <= rsp_char_in;
      rsp_hl_ff   <= rsp_hl_in;
      rsp_st_ff   <= rsp_st_in;
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff          <= req_op;
         row_ff         <= req_row;
         col_ff         <= req_col;
         ls_ff          <= req_line_start;
         run_cell_ff.ch <= req_char_code;
         run_cell_ff.hl <= req_highlight;
         bottom_ff      <= req_bottom;
         right_ff       <= req_right_edge;
         rows_ff        <= req_scroll_rows;
         cols_ff        <= req_scroll_cols;
      end
   end

   // store address select
   always_comb begin
      addr_row = row_ff;
      addr_col = col_ff;
      if (cmd.run_step) begin
         addr_row = cur_row_ff;
         addr_col = cur_col_ff;
      end else if (cmd.sc_copy) begin
         addr_row = tgt[ROW_W-1:0];
         addr_col = sc_ff;
      end else if (cmd.sc_read || cmd.sc_blank) begin
         addr_row = sr_ff;
         addr_col = sc_ff;
      end
   end

   assign mem_addr = cmd.clr_step ? clr_addr_ff : cell_addr(addr_row, addr_col);
   assign mem_we   = cmd.clr_step | cmd.run_step | cmd.sc_copy | cmd.sc_blank;
   assign mem_re   = cmd.sc_read | cmd.rd_issue;

   always_comb begin
      mem_wdata = '0;
      if (cmd.run_step) begin
         mem_wdata = run_cell_ff;
      end else if (cmd.sc_copy) begin
         mem_wdata = rd_data_ff;
      end
   end

   // single-port cell memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_addr];
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_char      = rsp_char_ff;
   assign rsp_cell_highlight = rsp_hl_ff;
   assign rsp_status         = rsp_st_ff;

endmodule
`default_nettype wire

/* sv/text_cell_grid_engine_top.sv */
`default_nettype none
// An item is accepted, decoded and stepped through the store: a run write writes
// its cells, a scroll copies or blanks each cell, a clear blanks every entry.
// The result is loaded into the output register once the previous one has left.
// At most one store access per cycle; a new item is taken in the cycle after the
// previous result is loaded. After reset all MAX_WIDTH*MAX_HEIGHT store entries
// (32768 by default) are swept blank, with req_ready low.
// ----------------------------------------------------------------------------
// text_cell_grid_engine_top: character-cell grid store
// Run writes, row scrolls, clears and cell reads on a grid of character and
// highlight cells, with a controller stepping a single-port cell memory.
// ----------------------------------------------------------------------------
module text_cell_grid_engine_top #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [tcg_pkg::OP_W-1:0]              req_op,
   input  logic [tcg_pkg::ROW_W-1:0]             req_row,
   input  logic [tcg_pkg::COL_W-1:0]             req_col,
   input  logic                                  req_line_start,
   input  logic [tcg_pkg::CHAR_W-1:0]            req_char_code,
   input  logic [tcg_pkg::HL_W-1:0]              req_highlight,
   input  logic [tcg_pkg::REP_W-1:0]             req_repeat_req,
   input  logic [tcg_pkg::ROW_W-1:0]             req_bottom,
   input  logic [tcg_pkg::COL_W-1:0]             req_right_edge,
   input  logic signed [tcg_pkg::SROW_W-1:0]     req_scroll_rows,
   input  logic signed [tcg_pkg::SCOL_W-1:0]     req_scroll_cols,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tcg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tcg_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [tcg_pkg::CHAR_W-1:0]            rsp_cell_char,
   output logic [tcg_pkg::HL_W-1:0]              rsp_cell_highlight,
   output logic [tcg_pkg::ST_W-1:0]              rsp_status
);
   import tcg_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   tcg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // cell store and registers
   tcg_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_op             (req_op),
      .req_row            (req_row),
      .req_col            (req_col),
      .req_line_start     (req_line_start),
      .req_char_code      (req_char_code),
      .req_highlight      (req_highlight),
      .req_repeat_req     (req_repeat_req),
      .req_bottom         (req_bottom),
      .req_right_edge     (req_right_edge),
      .req_scroll_rows    (req_scroll_rows),
      .req_scroll_cols    (req_scroll_cols),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_highlight (rsp_cell_highlight),
      .rsp_status         (rsp_status)
   );

endmodule
`default_nettype wire

/* test/text_cell_grid_engine_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_cell_grid_engine_top_tb: self-checking bench for the cell grid engine
// Drives run writes, scrolls, clears and reads through the request channel
// under several grid sizes. A scoreboard keeps its own copy of the cell store
// and cursor, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module text_cell_grid_engine_top_tb;
   import tcg_pkg::*;

   localparam int GRID_MAX_W  = 256;
   localparam int GRID_MAX_H  = 128;
   localparam int GRID_CELLS  = GRID_MAX_W * GRID_MAX_H;
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int TAIL_CYCLES = 40;
   localparam int PHASES      = 9;

   // one request item as seen on the req_ ports
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic              line_start;
      logic [CHAR_W-1:0] char_code;
      logic [HL_W-1:0]   highlight;
      logic [REP_W-1:0]  repeat_req;
      logic [ROW_W-1:0]  bottom;
      logic [COL_W-1:0]  right_edge;
      logic [SROW_W-1:0] scroll_rows;
      logic [SCOL_W-1:0] scroll_cols;
   } grid_req_type;

   // one result item as seen on the rsp_ ports
   typedef struct packed {
      logic [CHAR_W-1:0] cell_char;
      logic [HL_W-1:0]   cell_highlight;
      logic [ST_W-1:0]   status;
   } grid_rsp_type;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow grid, cursor and size registers plus pending results
   // -------------------------------------------------------------------------
   class grid_scoreboard;
      cell_type         cells [GRID_CELLS];
      logic [6:0]       cur_row;
      logic [8:0]       cur_col;
      bit               line_ok;
      logic [COL_W-1:0] width_reg;
      logic [ROW_W-1:0] height_reg;
      grid_rsp_type     expected_q [$];
      int               errors;

      function new();
         blank_all();
         cur_row    = '0;
         cur_col    = '0;
         line_ok    = 1'b0;
         width_reg  = GRID_WIDTH_RST;
         height_reg = GRID_HEIGHT_RST;
         errors     = 0;
      endfunction

      function void blank_all();
         foreach (cells[i]) cells[i] = '0;
      endfunction

      function int cell_addr(int r, int c);
         return (r * GRID_MAX_W + c) % GRID_CELLS;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == REG_GRID_WIDTH) width_reg = data;
         else height_reg = data[ROW_W-1:0];
      endfunction

      // predict the result of one accepted item and update the shadow grid
      function void note_item(grid_req_type it);
         int w, h, r, c, n, t, k;
         int top, bot, left, right, rows, mag;
         grid_rsp_type res;
         w = (width_reg < GRID_MAX_W) ? int'(width_reg) : GRID_MAX_W;
         h = (height_reg < GRID_MAX_H) ? int'(height_reg) : GRID_MAX_H;
         res = '0;
         res.status = ST_DONE;
         case (it.op)
            OP_RUN: begin
               // a new line takes row and col, or is rejected outright
               if (it.line_start) begin
                  if (it.row >= h || it.col >= w) begin
                     line_ok = 1'b0;
                     res.status = ST_REJECT;
                  end else begin
                     line_ok = 1'b1;
                     cur_row = it.row[6:0];
                     cur_col = it.col;
                  end
               end
               if (res.status == ST_DONE) begin
                  if (!line_ok || cur_row >= h) begin
                     res.status = ST_REJECT;
                  end else begin
                     // fill along the row, clipped at the width
                     n = 0;
                     while (n < it.repeat_req && cur_col < w) begin
                        cells[cell_addr(cur_row, cur_col)].ch = it.char_code;
                        cells[cell_addr(cur_row, cur_col)].hl = it.highlight;
                        cur_col++;
                        n++;
                     end
                     if (n == 0) res.status = ST_EMPTY;
                  end
               end
            end
            OP_SCROLL: begin
               top   = it.row;
               bot   = it.bottom;
               left  = it.col;
               right = it.right_edge;
               rows  = $signed(it.scroll_rows);
               mag   = (rows < 0) ? -rows : rows;
               if (it.scroll_cols != '0) res.status = ST_UNSUP;
               else if (w == 0 || h == 0) res.status = ST_REJECT;
               else if (top >= bot || bot > h) res.status = ST_REJECT;
               else if (left >= right || right > w) res.status = ST_REJECT;
               else if (mag > h) res.status = ST_REJECT;
               else if (rows == 0) res.status = ST_EMPTY;
               else begin
                  // up moves walk rows top-down, down moves bottom-up
                  for (k = 0; k < bot - top; k++) begin
                     r = (rows > 0) ? top + k : bot - 1 - k;
                     t = r - rows;
                     for (c = left; c < right; c++) begin
                        if (t >= 0 && t < h) cells[cell_addr(t, c)] = cells[cell_addr(r, c)];
                        else cells[cell_addr(r, c)] = '0;
                     end
                  end
               end
            end
            OP_CLEAR: blank_all();
            OP_READ: begin
               if (it.row < h && it.col < w) begin
                  res.cell_char      = cells[cell_addr(it.row, it.col)].ch;
                  res.cell_highlight = cells[cell_addr(it.row, it.col)].hl;
               end else begin
                  res.status = ST_REJECT;
               end
            end
         endcase
         expected_q.push_back(res);
      endfunction

      function void report(string what, logic [31:0] want, logic [31:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      endfunction

      // compare one result with the oldest prediction
      function void check_result(grid_rsp_type got);
         grid_rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result with no item outstanding, expected none, actual %0h/%0h/%0h",
                     $time, got.cell_char, got.cell_highlight, got.status);
            return;
         end
         want = expected_q.pop_front();
         if (got.cell_char !== want.cell_char)
            report("cell_char", want.cell_char, got.cell_char);
         if (got.cell_highlight !== want.cell_highlight)
            report("cell_highlight", want.cell_highlight, got.cell_highlight);
         if (got.status !== want.status)
            report("status", want.status, got.status);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block under test
   // -------------------------------------------------------------------------
   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [OP_W-1:0]   req_op;
   logic [ROW_W-1:0]  req_row;
   logic [COL_W-1:0]  req_col;
   logic              req_line_start;
   logic [CHAR_W-1:0] req_char_code;
   logic [HL_W-1:0]   req_highlight;
   logic [REP_W-1:0]  req_repeat_req;
   logic [ROW_W-1:0]  req_bottom;
   logic [COL_W-1:0]  req_right_edge;
   logic [SROW_W-1:0] req_scroll_rows;
   logic [SCOL_W-1:0] req_scroll_cols;
   logic              csr_valid;
   logic              csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [CHAR_W-1:0] rsp_cell_char;
   logic [HL_W-1:0]   rsp_cell_highlight;
   logic [ST_W-1:0]   rsp_status;

   grid_scoreboard sb;
   bit             calm = 1'b0;    // no idling on either side
   int             cur_w = 80;     // effective sizes, for shaping stimulus
   int             cur_h = 24;
   int             cycle_count = 0;

   int phase_w [PHASES] = '{16, 256, 1, 40, 511, 8, 0, 12, 80};
   int phase_h [PHASES] = '{8, 128, 1, 12, 511, 4, 5, 0, 24};
   int phase_n [PHASES] = '{200, 180, 80, 200, 150, 200, 60, 60, 320};

   text_cell_grid_engine_top #(
      .MAX_WIDTH  (GRID_MAX_W),
      .MAX_HEIGHT (GRID_MAX_H)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_row            (req_row),
      .req_col            (req_col),
      .req_line_start     (req_line_start),
      .req_char_code      (req_char_code),
      .req_highlight      (req_highlight),
      .req_repeat_req     (req_repeat_req),
      .req_bottom         (req_bottom),
      .req_right_edge     (req_right_edge),
      .req_scroll_rows    (req_scroll_rows),
      .req_scroll_cols    (req_scroll_cols),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_highlight (rsp_cell_highlight),
      .rsp_status         (rsp_status)
   );

   // clock: 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side backpressure
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 14);
   end

   // sample handshakes on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(grid_rsp_type'{rsp_cell_char, rsp_cell_highlight, rsp_status});
         if (req_valid && req_ready)
            sb.note_item(grid_req_type'{req_op, req_row, req_col, req_line_start, req_char_code,
                                        req_highlight, req_repeat_req, req_bottom,
                                        req_right_edge, req_scroll_rows, req_scroll_cols});
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_wdata);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("text_cell_grid_engine_top_tb NOT OK");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic int rnd_below(int n);
      return (n > 0) ? int'($urandom_range(0, n - 1)) : 0;
   endfunction

   function automatic grid_req_type mk_item(logic [OP_W-1:0] op, int row, int col, int ls,
                                            int ch, int hl, int rep, int bot, int right,
                                            int srows, int scols);
      grid_req_type it;
      it.op          = op;
      it.row         = ROW_W'(row);
      it.col         = COL_W'(col);
      it.line_start  = ls[0];
      it.char_code   = CHAR_W'(ch);
      it.highlight   = HL_W'(hl);
      it.repeat_req  = REP_W'(rep);
      it.bottom      = ROW_W'(bot);
      it.right_edge  = COL_W'(right);
      it.scroll_rows = SROW_W'(srows);
      it.scroll_cols = SCOL_W'(scols);
      return it;
   endfunction

   // mostly well-formed lines, runs, reads and scrolls, with rare clears, on random content
   function automatic grid_req_type random_item();
      grid_req_type it;
      int sel, top, left, rep;
      sel = $urandom_range(0, 199);
      it  = mk_item(OP_W'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom);
      case ($urandom_range(0, 9))
         0:       rep = $urandom;
         1, 2, 3: rep = rnd_below(cur_w + 3);
         default: rep = $urandom_range(0, 6);
      endcase
      if (sel == 0) begin
         it.op = OP_CLEAR;
      end else if (sel < 56) begin
         it.op         = OP_RUN;
         it.line_start = 1'b1;
         it.row        = ROW_W'(($urandom_range(0, 9) == 0) ? rnd_below(cur_h + 3)
                                                            : rnd_below(cur_h));
         it.col        = COL_W'(($urandom_range(0, 9) == 0) ? rnd_below(cur_w + 3)
                                                            : rnd_below(cur_w));
         it.repeat_req = REP_W'(rep);
      end else if (sel < 101) begin
         it.op         = OP_RUN;
         it.line_start = 1'b0;
         it.repeat_req = REP_W'(rep);
      end else if (sel < 141) begin
         it.op  = OP_READ;
         it.row = ROW_W'(($urandom_range(0, 99) < 85) ? rnd_below(cur_h) : rnd_below(cur_h + 2));
         it.col = COL_W'(($urandom_range(0, 99) < 85) ? rnd_below(cur_w) : rnd_below(cur_w + 2));
      end else if (sel < 176) begin
         // small regions keep the walk short even on the largest grid
         it.op         = OP_SCROLL;
         top           = rnd_below(cur_h);
         left          = rnd_below(cur_w);
         it.row        = ROW_W'(top);
         it.col        = COL_W'(left);
         it.bottom     = ROW_W'(top + 1 + rnd_below((cur_h - top < 6) ? cur_h - top : 6));
         it.right_edge = COL_W'(left + 1 + rnd_below((cur_w - left < 16) ? cur_w - left : 16));
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: it.scroll_rows = SROW_W'(int'($urandom_range(0, 6)) - 3);
            5, 6, 7, 8:    it.scroll_rows = SROW_W'(rnd_below(2 * cur_h + 1) - cur_h);
            default: ;
         endcase
         if ($urandom_range(0, 9) != 0) it.scroll_cols = '0;
         if ($urandom_range(0, 9) == 0) it.bottom = ROW_W'(cur_h + int'($urandom_range(0, 1)));
      end else if (it.op == OP_CLEAR) begin
         // clears are slow, keep noise from adding more
         it.op = OP_READ;
      end
      return it;
   endfunction

   // present one item and hold it until accepted; called at a falling edge
   task automatic send_item(input grid_req_type it);
      while (!calm && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= it.op;
      req_row         <= it.row;
      req_col         <= it.col;
      req_line_start  <= it.line_start;
      req_char_code   <= it.char_code;
      req_highlight   <= it.highlight;
      req_repeat_req  <= it.repeat_req;
      req_bottom      <= it.bottom;
      req_right_edge  <= it.right_edge;
      req_scroll_rows <= it.scroll_rows;
      req_scroll_cols <= it.scroll_cols;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // write both size registers; block must be idle
   task automatic set_grid(input int w_data, input int h_data);
      logic [CSR_DATA_W-1:0] w_reg;
      logic [ROW_W-1:0]      h_reg;
      w_reg = CSR_DATA_W'(w_data);
      h_reg = ROW_W'(h_data);
      for (int k = 0; k < 2; k++) begin
         csr_valid <= 1'b1;
         csr_index <= (k == 0) ? REG_GRID_WIDTH : REG_GRID_HEIGHT;
         csr_wdata <= CSR_DATA_W'((k == 0) ? w_data : h_data);
         do @(posedge clock); while (!(csr_valid && csr_ready));
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      @(negedge clock);
      cur_w = (w_reg < GRID_MAX_W) ? int'(w_reg) : GRID_MAX_W;
      cur_h = (h_reg < GRID_MAX_H) ? int'(h_reg) : GRID_MAX_H;
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      sb              = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = '0;
      req_row         = '0;
      req_col         = '0;
      req_line_start  = 1'b0;
      req_char_code   = '0;
      req_highlight   = '0;
      req_repeat_req  = '0;
      req_bottom      = '0;
      req_right_edge  = '0;
      req_scroll_rows = '0;
      req_scroll_cols = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed items on the reset size of 80 by 24
      send_item(mk_item(OP_READ,   0,   0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(mk_item(OP_RUN,    0,   0, 0, 'h41, 1, 4, 0, 0, 0, 0));        // no line yet
      send_item(mk_item(OP_RUN,   24,   0, 1, 'h41, 1, 4, 0, 0, 0, 0));        // row off grid
      send_item(mk_item(OP_RUN,    0,  80, 1, 'h41, 1, 4, 0, 0, 0, 0));        // col off grid
      send_item(mk_item(OP_RUN,    5,   5, 0, 'h41, 1, 3, 0, 0, 0, 0));        // rejected line
      send_item(mk_item(OP_RUN,   23,  70, 1, 'h1FFFFF, 'hFFFF, 'hFFFF, 0, 0, 0, 0));
      send_item(mk_item(OP_RUN,    0,   0, 0, 'h10FFFF, 'h1234, 5, 0, 0, 0, 0)); // at line end
      send_item(mk_item(OP_RUN,    0,   0, 1, 'h20, 7, 0, 0, 0, 0, 0));        // zero repeat
      send_item(mk_item(OP_RUN,    0,   0, 0, 'h10FFFF, 'hFF, 3, 0, 0, 0, 0));
      send_item(mk_item(OP_READ,  23,  79, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(mk_item(OP_READ,  24,   0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(mk_item(OP_READ,   0,  80, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(mk_item(OP_READ, 255, 511, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(mk_item(OP_SCROLL, 0,   0, 0, 0, 0, 0, 24, 80, 1, 1));         // column shift
      send_item(mk_item(OP_SCROLL, 0,   0, 0, 0, 0, 0, 24, 80, 1, -256));
      send_item(mk_item(OP_SCROLL, 5,   0, 0, 0, 0, 0,  5, 80, 1, 0));         // empty rows
      send_item(mk_item(OP_SCROLL, 0,   0, 0, 0, 0, 0, 25, 80, 1, 0));         // bottom too far
      send_item(mk_item(OP_SCROLL, 0,  10, 0, 0, 0, 0, 24, 10, 1, 0));         // empty columns
      send_item(mk_item(OP_SCROLL, 0,   0, 0, 0, 0, 0, 24, 81, 1, 0));         // right too far
      send_item(mk_item(OP_SCROLL, 0,   0, 0, 0, 0, 0, 24, 80, -256, 0));      // too many rows
      send_item(mk_item(OP_SCROLL, 0,   0, 0, 0, 0, 0, 24, 80, 0, 0));         // no move
      send_item(mk_item(OP_SCROLL, 0,   0, 0, 0, 0, 0, 24, 80, 1, 0));
      send_item(mk_item(OP_SCROLL, 0,  60, 0, 0, 0, 0, 24, 80, -2, 0));
      send_item(mk_item(OP_READ,  23,  79, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(mk_item(OP_SCROLL, 10,  0, 0, 0, 0, 0, 12, 80, 24, 0));        // all off grid
      send_item(mk_item(OP_CLEAR,  0,   0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(mk_item(OP_READ,  21,  79, 0, 0, 0, 0, 0, 0, 0, 0));

      // cursor row left past the height by a size change
      send_item(mk_item(OP_RUN,   20,   0, 1, 'h55, 3, 1, 0, 0, 0, 0));
      drain_results();
      set_grid(80, 10);
      send_item(mk_item(OP_RUN,    0,   0, 0, 'h55, 3, 2, 0, 0, 0, 0));

      // one full-size scroll on the largest grid
      drain_results();
      set_grid(256, 128);
      send_item(mk_item(OP_RUN,  126, 250, 1, 'h7A, 'h9, 'hFFFF, 0, 0, 0, 0));
      send_item(mk_item(OP_SCROLL, 0,   0, 0, 0, 0, 0, 128, 256, -1, 0));
      send_item(mk_item(OP_READ, 127, 255, 0, 0, 0, 0, 0, 0, 0, 0));

      // random phases, one grid size each
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_results();
         set_grid(phase_w[ph], phase_h[ph]);
         calm = (ph == 3);
         for (int k = 0; k < phase_n[ph]; k++) begin
            // hold off once until everything outstanding is back
            if (ph == 0 && k == 100) drain_results();
            send_item(random_item());
         end
      end
      calm = 1'b0;

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("text_cell_grid_engine_top_tb OK");
      else
         $display("text_cell_grid_engine_top_tb NOT OK");
      $finish;
   end

endmodule

/* sim.f */
sv/tcg_pkg.sv
sv/tcg_ctrl.sv
sv/tcg_datapath.sv
sv/text_cell_grid_engine_top.sv
test/text_cell_grid_engine_top_tb.sv
